// ===== rtl/plt_pkg.sv =====
// Shared types and constants of the participant lease table.
package plt_pkg;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEASE_DURATION = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DISCOVERY_ENABLE = 1'd1;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [31:0] LEASE_RESET = 32'd10000;

   // Word field widths.
   localparam int STATUS_BITS = 2;
   localparam int COUNT_OUT_BITS = 5;

   // Result status codes.
   localparam logic [STATUS_BITS-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_SHORT = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_BAD_MAGIC = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd3;

   // Header checks.
   localparam logic [15:0] MIN_PACKET_LEN = 16'd20;
   localparam logic [31:0] MAGIC_WORD = {8'h52, 8'h54, 8'h50, 8'h53};

   // Opcodes of an input word.
   localparam logic OP_PACKET = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Depth of the command queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_REPLY,
      CMD_PACKET,
      CMD_TICK
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [STATUS_BITS-1:0] status;
   } cmd_ctl_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_COMMIT
   } back_state_type;

endpackage

// ===== rtl/plt_req_if.sv =====
// Request channel of the participant lease table.
interface plt_req_if #(
   parameter int TIME_BITS = 48
);
   logic valid;
   logic ready;
   logic opcode;
   logic [TIME_BITS-1:0] time_ms;
   logic [15:0] packet_length;
   logic [31:0] header_magic;
   logic [31:0] prefix_upper;
   logic [63:0] prefix_lower;

   modport source (output valid, opcode, time_ms, packet_length, header_magic,
                   prefix_upper, prefix_lower, input ready);
   modport sink (input valid, opcode, time_ms, packet_length, header_magic,
                 prefix_upper, prefix_lower, output ready);
endinterface

// ===== rtl/plt_rsp_if.sv =====
// Response channel of the participant lease table.
interface plt_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] status;
   logic new_participant;
   logic [4:0] participant_count;
   logic [4:0] purged_count;

   modport source (output valid, status, new_participant, participant_count,
                   purged_count, input ready);
   modport sink (input valid, status, new_participant, participant_count,
                 purged_count, output ready);
endinterface

// ===== rtl/plt_front.sv =====
// Front end: accepts request words and classifies them into back-end commands.
module plt_front #(
   parameter int TIME_BITS = 48
) (
   plt_req_if.sink req_chan,
   input logic discovery_enable,
   output logic cmd_valid,
   input logic cmd_ready,
   output plt_pkg::cmd_ctl_type cmd_ctl,
   output logic [TIME_BITS-1:0] cmd_time,
   output logic [31:0] cmd_key_hi,
   output logic [63:0] cmd_key_lo
);

   assign cmd_valid = req_chan.valid;
   assign req_chan.ready = cmd_ready;
   assign cmd_time = req_chan.time_ms;
   assign cmd_key_hi = req_chan.prefix_upper;
   assign cmd_key_lo = req_chan.prefix_lower;

   // Rejected packets and disabled ticks become a plain reply.
   always_comb begin
      cmd_ctl.kind = plt_pkg::CMD_REPLY;
      cmd_ctl.status = plt_pkg::ST_OK;
      if (req_chan.opcode == plt_pkg::OP_TICK) begin
         if (discovery_enable) begin
            cmd_ctl.kind = plt_pkg::CMD_TICK;
         end
      end else if (req_chan.packet_length < plt_pkg::MIN_PACKET_LEN) begin
         cmd_ctl.status = plt_pkg::ST_SHORT;
      end else if (req_chan.header_magic != plt_pkg::MAGIC_WORD) begin
         cmd_ctl.status = plt_pkg::ST_BAD_MAGIC;
      end else begin
         cmd_ctl.kind = plt_pkg::CMD_PACKET;
      end
   end

endmodule

// ===== rtl/plt_queue.sv =====
// Short command queue between the front end and the back end.
module plt_queue #(
   parameter int WIDTH = 8
) (
   input logic clock,
   input logic reset,
   input logic push_valid,
   output logic push_ready,
   input logic [WIDTH-1:0] push_data,
   output logic pop_valid,
   input logic pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] slot_ff [plt_pkg::QUEUE_DEPTH];
   logic [plt_pkg::QPTR_BITS-1:0] wr_ptr_ff;
   logic [plt_pkg::QPTR_BITS-1:0] rd_ptr_ff;
   logic [plt_pkg::QCNT_BITS-1:0] count_ff;
   logic push_fire;
   logic pop_fire;

   assign push_ready = count_ff != plt_pkg::QCNT_BITS'(plt_pkg::QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data = slot_ff[rd_ptr_ff];
   assign push_fire = push_valid && push_ready;
   assign pop_fire = pop_valid && pop_ready;

   function automatic logic [plt_pkg::QPTR_BITS-1:0] next_ptr(
      input logic [plt_pkg::QPTR_BITS-1:0] ptr
   );
      if (ptr == plt_pkg::QPTR_BITS'(plt_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push_fire) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop_fire) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push_fire && !pop_fire) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop_fire && !push_fire) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/plt_back.sv =====
// Back end: scans the table for lookups and purges, updates it and registers the result.
module plt_back #(
   parameter int TABLE_ENTRIES = 16,
   parameter int TIME_BITS = 48
) (
   input logic clock,
   input logic reset,
   input logic [31:0] lease_duration,
   input logic cmd_valid,
   output logic cmd_ready,
   input plt_pkg::cmd_ctl_type cmd_ctl,
   input logic [TIME_BITS-1:0] cmd_time,
   input logic [31:0] cmd_key_hi,
   input logic [63:0] cmd_key_lo,
   plt_rsp_if.source rsp_chan
);

   localparam int IDX_BITS = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_BITS = $clog2(TABLE_ENTRIES + 1);

   plt_pkg::back_state_type state_ff;
   plt_pkg::back_state_type state_in;

   plt_pkg::cmd_ctl_type ctl_ff;
   logic [TIME_BITS-1:0] time_ff;
   logic [31:0] key_hi_ff;
   logic [63:0] key_lo_ff;
   logic [IDX_BITS-1:0] idx_ff;
   logic hit_found_ff;
   logic [IDX_BITS-1:0] hit_idx_ff;
   logic free_found_ff;
   logic [IDX_BITS-1:0] free_idx_ff;
   logic [CNT_BITS-1:0] purged_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff;

   logic [31:0] entry_hi_ff [TABLE_ENTRIES];
   logic [63:0] entry_lo_ff [TABLE_ENTRIES];
   logic [TIME_BITS-1:0] entry_seen_ff [TABLE_ENTRIES];

   logic rsp_valid_ff;
   logic [plt_pkg::STATUS_BITS-1:0] rsp_status_ff;
   logic rsp_new_ff;
   logic [plt_pkg::COUNT_OUT_BITS-1:0] rsp_count_ff;
   logic [plt_pkg::COUNT_OUT_BITS-1:0] rsp_purged_ff;

   // Controls from the sequencer.
   logic slot_free;
   logic load_cmd;
   logic scan_step;
   logic scan_last;
   logic commit_fire;

   // Scan datapath.
   logic rd_valid;
   logic key_match;
   logic [TIME_BITS:0] age;
   logic expired;

   // Commit datapath.
   logic entry_write;
   logic [IDX_BITS-1:0] entry_idx;
   logic do_insert;
   logic [plt_pkg::STATUS_BITS-1:0] res_status;
   logic res_new;
   logic [CNT_BITS-1:0] res_count;
   logic [CNT_BITS-1:0] res_purged;
   logic [CNT_BITS+plt_pkg::COUNT_OUT_BITS-1:0] count_ext;
   logic [CNT_BITS+plt_pkg::COUNT_OUT_BITS-1:0] purged_ext;

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign scan_last = idx_ff == IDX_BITS'(TABLE_ENTRIES - 1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         plt_pkg::BK_IDLE: begin
            if (cmd_valid) begin
               state_in = (cmd_ctl.kind == plt_pkg::CMD_REPLY) ? plt_pkg::BK_COMMIT
                                                                : plt_pkg::BK_SCAN;
            end
         end
         plt_pkg::BK_SCAN: begin
            if (scan_last) begin
               state_in = plt_pkg::BK_COMMIT;
            end
         end
         plt_pkg::BK_COMMIT: begin
            if (slot_free) begin
               state_in = plt_pkg::BK_IDLE;
            end
         end
         default: state_in = plt_pkg::BK_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      load_cmd = 1'b0;
      scan_step = 1'b0;
      commit_fire = 1'b0;
      unique case (state_ff)
         plt_pkg::BK_IDLE: load_cmd = cmd_valid;
         plt_pkg::BK_SCAN: scan_step = 1'b1;
         plt_pkg::BK_COMMIT: commit_fire = slot_free;
         default: ;
      endcase
   end

   assign cmd_ready = load_cmd;

   // One entry is examined per cycle.
   assign rd_valid = valid_ff[idx_ff];
   assign key_match = (entry_hi_ff[idx_ff] == key_hi_ff) && (entry_lo_ff[idx_ff] == key_lo_ff);
   assign age = {1'b0, time_ff} - {1'b0, entry_seen_ff[idx_ff]};
   assign expired = !age[TIME_BITS] && (age[TIME_BITS-1:0] > TIME_BITS'(lease_duration));

   // Result of the finished command.
   always_comb begin
      entry_write = 1'b0;
      entry_idx = hit_idx_ff;
      do_insert = 1'b0;
      res_status = plt_pkg::ST_OK;
      res_new = 1'b0;
      res_count = count_ff;
      res_purged = '0;
      case (ctl_ff.kind)
         plt_pkg::CMD_PACKET: begin
            if (hit_found_ff) begin
               entry_write = 1'b1;
            end else if (free_found_ff) begin
               entry_write = 1'b1;
               entry_idx = free_idx_ff;
               do_insert = 1'b1;
               res_new = 1'b1;
               res_count = count_ff + 1'b1;
            end else begin
               res_status = plt_pkg::ST_FULL;
            end
         end
         plt_pkg::CMD_TICK: res_purged = purged_ff;
         default: res_status = ctl_ff.status;
      endcase
   end

   assign count_ext = {{plt_pkg::COUNT_OUT_BITS{1'b0}}, res_count};
   assign purged_ext = {{plt_pkg::COUNT_OUT_BITS{1'b0}}, res_purged};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= plt_pkg::BK_IDLE;
         valid_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (scan_step && ctl_ff.kind == plt_pkg::CMD_TICK && rd_valid && expired) begin
            valid_ff[idx_ff] <= 1'b0;
            count_ff <= count_ff - 1'b1;
         end
         if (commit_fire && do_insert) begin
            valid_ff[entry_idx] <= 1'b1;
            count_ff <= res_count;
         end
         if (commit_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Command and scan registers.
   always_ff @(posedge clock) begin
      if (load_cmd) begin
         ctl_ff <= cmd_ctl;
         time_ff <= cmd_time;
         key_hi_ff <= cmd_key_hi;
         key_lo_ff <= cmd_key_lo;
         idx_ff <= '0;
         hit_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
         hit_idx_ff <= '0;
         free_idx_ff <= '0;
         purged_ff <= '0;
      end else if (scan_step) begin
         if (!scan_last) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (rd_valid) begin
            if (!hit_found_ff && key_match) begin
               hit_found_ff <= 1'b1;
               hit_idx_ff <= idx_ff;
            end
            if (ctl_ff.kind == plt_pkg::CMD_TICK && expired) begin
               purged_ff <= purged_ff + 1'b1;
            end
         end else if (!free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff <= idx_ff;
         end
      end
   end

   // Entry storage, written only at commit.
   always_ff @(posedge clock) begin
      if (commit_fire && entry_write) begin
         entry_seen_ff[entry_idx] <= time_ff;
         if (do_insert) begin
            entry_hi_ff[entry_idx] <= key_hi_ff;
            entry_lo_ff[entry_idx] <= key_lo_ff;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (commit_fire) begin
         rsp_status_ff <= res_status;
         rsp_new_ff <= res_new;
         rsp_count_ff <= count_ext[plt_pkg::COUNT_OUT_BITS-1:0];
         rsp_purged_ff <= purged_ext[plt_pkg::COUNT_OUT_BITS-1:0];
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.new_participant = rsp_new_ff;
   assign rsp_chan.participant_count = rsp_count_ff;
   assign rsp_chan.purged_count = rsp_purged_ff;

endmodule

// ===== rtl/participant_lease_table.sv =====
// Top level of the participant lease table: configuration registers and block wiring.
//
//   Channel    Direction  Handshake          Word
//   req_chan   in         valid / ready      opcode, time, length, magic, 96-bit prefix
//   rsp_chan   out        valid / ready      status, new flag, participant and purge counts
//   csr_*      in         csr_wr_en only     register index and 32-bit write data
//
// A packet that passes its header checks, and a tick while discovery is enabled, are
// loaded, scanned against every table entry and committed in the back end, and the
// commit waits while the output register is full. Rejected packets and disabled ticks
// skip the scan. A two-word queue sits between front and back, so up to two new words
// are accepted while the back end is busy and while a finished result waits in the
// output register. Reset is synchronous: it clears the valid bits, the entry count, the
// queue and the output valid flag at once, with no clearing pass; entry contents are never
// read while their valid bit is clear.
module participant_lease_table #(
   parameter int TABLE_ENTRIES = 16,
   parameter int TIME_BITS = 48
) (
   input logic clock,
   input logic reset,
   plt_req_if.sink req_chan,
   plt_rsp_if.source rsp_chan,
   input logic csr_wr_en,
   input logic [plt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic [plt_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int CTL_BITS = $bits(plt_pkg::cmd_ctl_type);
   localparam int CMD_BITS = CTL_BITS + TIME_BITS + 32 + 64;

   // Configuration registers.
   logic [31:0] lease_duration_ff;
   logic discovery_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lease_duration_ff <= plt_pkg::LEASE_RESET;
         discovery_enable_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            plt_pkg::CSR_LEASE_DURATION: lease_duration_ff <= csr_wdata[31:0];
            plt_pkg::CSR_DISCOVERY_ENABLE: discovery_enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Front end to queue.
   logic front_valid;
   logic front_ready;
   plt_pkg::cmd_ctl_type front_ctl;
   logic [TIME_BITS-1:0] front_time;
   logic [31:0] front_key_hi;
   logic [63:0] front_key_lo;

   // Queue to back end.
   logic back_valid;
   logic back_ready;
   logic [CMD_BITS-1:0] back_data;
   plt_pkg::cmd_ctl_type back_ctl;
   logic [TIME_BITS-1:0] back_time;
   logic [31:0] back_key_hi;
   logic [63:0] back_key_lo;

   plt_front #(
      .TIME_BITS(TIME_BITS)
   ) u_front (
      .req_chan(req_chan),
      .discovery_enable(discovery_enable_ff),
      .cmd_valid(front_valid),
      .cmd_ready(front_ready),
      .cmd_ctl(front_ctl),
      .cmd_time(front_time),
      .cmd_key_hi(front_key_hi),
      .cmd_key_lo(front_key_lo)
   );

   plt_queue #(
      .WIDTH(CMD_BITS)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(front_valid),
      .push_ready(front_ready),
      .push_data({front_ctl, front_time, front_key_hi, front_key_lo}),
      .pop_valid(back_valid),
      .pop_ready(back_ready),
      .pop_data(back_data)
   );

   assign {back_ctl, back_time, back_key_hi, back_key_lo} = back_data;

   plt_back #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .TIME_BITS(TIME_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .lease_duration(lease_duration_ff),
      .cmd_valid(back_valid),
      .cmd_ready(back_ready),
      .cmd_ctl(back_ctl),
      .cmd_time(back_time),
      .cmd_key_hi(back_key_hi),
      .cmd_key_lo(back_key_lo),
      .rsp_chan(rsp_chan)
   );

endmodule
